### hdl/haptic_pull_force_unit_macros.svh
// -----------------------------------------------------------------------------
// Haptic pull force unit assertion macros
// Concurrent checks on the unit clock and reset; they compile away for synthesis.
// -----------------------------------------------------------------------------
`ifndef HAPTIC_PULL_FORCE_UNIT_MACROS_SVH
`define HAPTIC_PULL_FORCE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge out of reset.
`define HPF_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("haptic pull force unit: check failed");
// An implication checked in the same cycle.
`define HPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("haptic pull force unit: implication failed");
`else
`define HPF_ASSERT(lbl, cond)
`define HPF_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### hdl/hpf_pkg.sv
// -----------------------------------------------------------------------------
// Haptic pull force package
// Widths, register indexes, reset values and shared types of the unit.
// -----------------------------------------------------------------------------
package hpf_pkg;

  localparam int POS_BITS      = 24;
  localparam int FORCE_BITS    = 16;
  localparam int ROT_FRAC_BITS = 14;
  localparam int ROT_BITS      = 16;
  localparam int ROW_BITS      = 3 * ROT_BITS;

  // Difference vector, its squares and the squared length.
  localparam int VEC_BITS = POS_BITS + 1;
  localparam int SQR_BITS = 2 * VEC_BITS;
  localparam int D2_BITS  = SQR_BITS + 2;

  localparam int DIST_BITS    = 23;
  localparam int STR_BITS     = 20;
  localparam int LIM_BITS     = 15;
  localparam int CFG_BITS     = POS_BITS;
  localparam int CFG_IDX_BITS = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam int MAX_RST = 80000;
  localparam int MIN_RST = 1000;
  localparam int STR_RST = 50000;
  localparam int LIM_RST = 3000;

  // Saturation bounds of an output component.
  localparam logic signed [FORCE_BITS-1:0] F_MAX = {1'b0, {(FORCE_BITS-1){1'b1}}};
  localparam logic signed [FORCE_BITS-1:0] F_MIN = {1'b1, {(FORCE_BITS-2){1'b0}}, 1'b1};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_CENTER_Z  = 3'd2,
    CFG_MAX_DIST  = 3'd3,
    CFG_MIN_DIST  = 3'd4,
    CFG_STRENGTH  = 3'd5,
    CFG_LIMIT     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [POS_BITS-1:0] center_x;
    logic signed [POS_BITS-1:0] center_y;
    logic signed [POS_BITS-1:0] center_z;
    logic [DIST_BITS-1:0]       max_dist;
    logic [DIST_BITS-1:0]       min_dist;
    logic [STR_BITS-1:0]        strength;
    logic [LIM_BITS-1:0]        limit;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    center_x: '0,
    center_y: '0,
    center_z: '0,
    max_dist: DIST_BITS'(MAX_RST),
    min_dist: DIST_BITS'(MIN_RST),
    strength: STR_BITS'(STR_RST),
    limit:    LIM_BITS'(LIM_RST)
  };

  // One classified tick as it travels from the front to the back.
  typedef struct packed {
    logic signed [VEC_BITS-1:0]   vx;
    logic signed [VEC_BITS-1:0]   vy;
    logic signed [VEC_BITS-1:0]   vz;
    logic [ROW_BITS-1:0]          row0;
    logic [ROW_BITS-1:0]          row1;
    logic [ROW_BITS-1:0]          row2;
    logic signed [FORCE_BITS-1:0] cx;
    logic signed [FORCE_BITS-1:0] cy;
    logic signed [FORCE_BITS-1:0] cz;
    logic                         in_field;
    logic [D2_BITS-1:0]           d2;
  } item_t;

endpackage

### hdl/hpf_front.sv
// -----------------------------------------------------------------------------
// Haptic pull force front end
// Accepts ticks, forms the vector to the centre and its squared length, and
// classifies the tick against the field radii before queueing it.
// -----------------------------------------------------------------------------
module hpf_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hpf_pkg::cfg_t                        cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [hpf_pkg::POS_BITS-1:0]  tool_pos_x_i,
  input  logic signed [hpf_pkg::POS_BITS-1:0]  tool_pos_y_i,
  input  logic signed [hpf_pkg::POS_BITS-1:0]  tool_pos_z_i,
  input  logic [hpf_pkg::ROW_BITS-1:0]         rot_row0_i,
  input  logic [hpf_pkg::ROW_BITS-1:0]         rot_row1_i,
  input  logic [hpf_pkg::ROW_BITS-1:0]         rot_row2_i,
  input  logic signed [hpf_pkg::FORCE_BITS-1:0] contact_x_i,
  input  logic signed [hpf_pkg::FORCE_BITS-1:0] contact_y_i,
  input  logic signed [hpf_pkg::FORCE_BITS-1:0] contact_z_i,
  input  logic [hpf_pkg::QCNT_BITS-1:0]        q_cnt_i,
  output logic                                 push_o,
  output hpf_pkg::item_t                       item_o
);
  import hpf_pkg::*;

  logic                      v1_q, v2_q;
  logic                      accept;
  logic [QCNT_BITS:0]        occ;
  item_t                     s1_d, s1_q, s2_q;
  logic [SQR_BITS-1:0]       sq_d [3];
  logic [SQR_BITS-1:0]       sq_q [3];
  logic signed [SQR_BITS-1:0] ex, ey, ez;
  logic [2*DIST_BITS-1:0]    min_sq_d, min_sq_q, max_sq_d, max_sq_q;
  logic [D2_BITS-1:0]        d2;

  // Credit check: ticks in flight here plus queued ticks never exceed the queue.
  assign occ = {1'b0, q_cnt_i} + (QCNT_BITS+1)'(v1_q) + (QCNT_BITS+1)'(v2_q);
  assign in_stall_o = (occ >= (QCNT_BITS+1)'(QUEUE_DEPTH));
  assign accept = in_valid_i && !in_stall_o;

  // Difference vector from the tool to the centre.
  always_comb begin
    s1_d.vx       = VEC_BITS'(cfg_i.center_x) - VEC_BITS'(tool_pos_x_i);
    s1_d.vy       = VEC_BITS'(cfg_i.center_y) - VEC_BITS'(tool_pos_y_i);
    s1_d.vz       = VEC_BITS'(cfg_i.center_z) - VEC_BITS'(tool_pos_z_i);
    s1_d.row0     = rot_row0_i;
    s1_d.row1     = rot_row1_i;
    s1_d.row2     = rot_row2_i;
    s1_d.cx       = contact_x_i;
    s1_d.cy       = contact_y_i;
    s1_d.cz       = contact_z_i;
    s1_d.in_field = 1'b0;
    s1_d.d2       = '0;
  end

  // Squares of the three components.
  always_comb begin
    ex = SQR_BITS'(s1_q.vx);
    ey = SQR_BITS'(s1_q.vy);
    ez = SQR_BITS'(s1_q.vz);
    sq_d[0] = ex * ex;
    sq_d[1] = ey * ey;
    sq_d[2] = ez * ez;
  end

  // Squared radii are registered and follow the configuration in the next cycle.
  assign min_sq_d = (2*DIST_BITS)'(cfg_i.min_dist) * (2*DIST_BITS)'(cfg_i.min_dist);
  assign max_sq_d = (2*DIST_BITS)'(cfg_i.max_dist) * (2*DIST_BITS)'(cfg_i.max_dist);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      min_sq_q <= (2*DIST_BITS)'(MIN_RST) * (2*DIST_BITS)'(MIN_RST);
      max_sq_q <= (2*DIST_BITS)'(MAX_RST) * (2*DIST_BITS)'(MAX_RST);
    end else begin
      v1_q     <= accept;
      v2_q     <= v1_q;
      min_sq_q <= min_sq_d;
      max_sq_q <= max_sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s1_q;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= sq_d[i];
    end
  end

  // Squared length and field test; the result goes straight into the queue.
  always_comb begin
    d2 = D2_BITS'(sq_q[0]) + D2_BITS'(sq_q[1]) + D2_BITS'(sq_q[2]);
    item_o          = s2_q;
    item_o.d2       = d2;
    item_o.in_field = (d2 > D2_BITS'(min_sq_q)) && (d2 < D2_BITS'(max_sq_q));
  end

  assign push_o = v2_q;

endmodule

### hdl/hpf_queue.sv
// -----------------------------------------------------------------------------
// Haptic pull force queue
// Short first-in first-out buffer between the front end and the back end.
// -----------------------------------------------------------------------------
module hpf_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  hpf_pkg::item_t                item_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output hpf_pkg::item_t                item_o,
  output logic [hpf_pkg::QCNT_BITS-1:0] cnt_o
);
  import hpf_pkg::*;

  item_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q;
  logic                 do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign cnt_o   = cnt_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_BITS'(1);
      end
      cnt_q <= cnt_q + QCNT_BITS'(push_i) - QCNT_BITS'(do_pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### hdl/hpf_back.sv
// -----------------------------------------------------------------------------
// Haptic pull force back end
// Pipelined square root, magnitude divider, direction dividers, rotation into
// tool coordinates, rounding and saturation, ending in the output register.
// -----------------------------------------------------------------------------
module hpf_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  hpf_pkg::cfg_t                         cfg_i,
  input  logic                                  q_valid_i,
  input  hpf_pkg::item_t                        item_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [hpf_pkg::FORCE_BITS-1:0] force_x_o,
  output logic signed [hpf_pkg::FORCE_BITS-1:0] force_y_o,
  output logic signed [hpf_pkg::FORCE_BITS-1:0] force_z_o,
  output logic                                  in_field_o,
  output logic                                  saturated_o
);
  import hpf_pkg::*;

  localparam int SQ_STAGES   = D2_BITS / 2;
  localparam int ROOT_BITS   = SQ_STAGES;
  localparam int SQ_REM_BITS = ROOT_BITS + 2;
  localparam int PROD_BITS   = STR_BITS + DIST_BITS;
  localparam int DV_STAGES   = STR_BITS;
  localparam int NUM_BITS    = LIM_BITS + VEC_BITS;
  localparam int GQ_BITS     = LIM_BITS + 1;
  localparam int DG_STAGES   = GQ_BITS;
  localparam int G_BITS      = GQ_BITS + 1;
  localparam int PR_BITS     = ROT_BITS + G_BITS;
  localparam int ACC_BITS    = PR_BITS + 2;
  localparam int RND_BITS    = ACC_BITS - ROT_FRAC_BITS;
  localparam int TOT_BITS    = RND_BITS + 2;

  // Pipeline positions.
  localparam int I_MUL = SQ_STAGES;
  localparam int I_DV0 = I_MUL + 1;
  localparam int I_CLP = I_DV0 + DV_STAGES;
  localparam int I_NUM = I_CLP + 1;
  localparam int I_DG0 = I_NUM + 1;
  localparam int I_GV  = I_DG0 + DG_STAGES;
  localparam int I_ROT = I_GV + 1;
  localparam int I_ACC = I_ROT + 1;
  localparam int N_STG = I_ACC + 1;

  localparam logic [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1) << (ROT_FRAC_BITS - 1);
  localparam logic signed [TOT_BITS-1:0] T_MAX = TOT_BITS'(F_MAX);
  localparam logic signed [TOT_BITS-1:0] T_MIN = TOT_BITS'(F_MIN);

  typedef struct packed {
    item_t                item;
    logic [DIST_BITS-1:0] d;
  } side_t;

  typedef struct packed {
    logic [D2_BITS-1:0]     num;
    logic [SQ_REM_BITS-1:0] rem;
    logic [ROOT_BITS-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] rem;
    logic [STR_BITS-1:0]  lq;
  } dv1_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] rem;
    logic [GQ_BITS-1:0]   lq;
  } dv2_t;

  // One bit of the integer square root.
  function automatic sq_t sq_step(sq_t s);
    logic [SQ_REM_BITS-1:0] t;
    logic [SQ_REM_BITS-1:0] trial;
    sq_t r;
    t     = {s.rem[SQ_REM_BITS-3:0], s.num[D2_BITS-1 -: 2]};
    trial = {s.root, 2'b01};
    r.num = {s.num[D2_BITS-3:0], 2'b00};
    if (t >= trial) begin
      r.rem  = t - trial;
      r.root = {s.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      r.rem  = t;
      r.root = {s.root[ROOT_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of the magnitude division.
  function automatic dv1_t dv1_step(dv1_t s, logic [DIST_BITS-1:0] dvs);
    logic [DIST_BITS:0] t;
    dv1_t r;
    t    = {s.rem, s.lq[STR_BITS-1]};
    r.lq = {s.lq[STR_BITS-2:0], 1'b0};
    if (t >= {1'b0, dvs}) begin
      t       = t - {1'b0, dvs};
      r.lq[0] = 1'b1;
    end
    r.rem = t[DIST_BITS-1:0];
    return r;
  endfunction

  // One quotient bit of a direction division.
  function automatic dv2_t dv2_step(dv2_t s, logic [DIST_BITS-1:0] dvs);
    logic [DIST_BITS:0] t;
    dv2_t r;
    t    = {s.rem, s.lq[GQ_BITS-1]};
    r.lq = {s.lq[GQ_BITS-2:0], 1'b0};
    if (t >= {1'b0, dvs}) begin
      t       = t - {1'b0, dvs};
      r.lq[0] = 1'b1;
    end
    r.rem = t[DIST_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [VEC_BITS-1:0] vec_of(item_t it, int i);
    logic signed [VEC_BITS-1:0] v;
    unique case (i)
      0:       v = it.vx;
      1:       v = it.vy;
      default: v = it.vz;
    endcase
    return v;
  endfunction

  function automatic logic signed [FORCE_BITS-1:0] contact_of(item_t it, int j);
    logic signed [FORCE_BITS-1:0] c;
    unique case (j)
      0:       c = it.cx;
      1:       c = it.cy;
      default: c = it.cz;
    endcase
    return c;
  endfunction

  // Matrix entry R[i][j].
  function automatic logic signed [ROT_BITS-1:0] rot_of(item_t it, int i, int j);
    logic [ROW_BITS-1:0] row;
    unique case (i)
      0:       row = it.row0;
      1:       row = it.row1;
      default: row = it.row2;
    endcase
    return row[j*ROT_BITS +: ROT_BITS];
  endfunction

  logic en;
  logic vld_q [N_STG];
  side_t side_d [N_STG];
  side_t side_q [N_STG];
  sq_t   sq_d [SQ_STAGES];
  sq_t   sq_q [SQ_STAGES];
  logic [PROD_BITS-1:0] prod_d, prod_q;
  dv1_t  dv_d [DV_STAGES];
  dv1_t  dv_q [DV_STAGES];
  logic [LIM_BITS-1:0] mag_d, mag_q;
  logic [NUM_BITS-1:0] num_d [3];
  logic [NUM_BITS-1:0] num_q [3];
  dv2_t  dg_d [DG_STAGES][3];
  dv2_t  dg_q [DG_STAGES][3];
  logic signed [G_BITS-1:0]   g_d [3];
  logic signed [G_BITS-1:0]   g_q [3];
  logic signed [PR_BITS-1:0]  pr_d [3][3];
  logic signed [PR_BITS-1:0]  pr_q [3][3];
  logic signed [ACC_BITS-1:0] acc_d [3];
  logic signed [ACC_BITS-1:0] acc_q [3];
  logic signed [FORCE_BITS-1:0] force_d [3];
  logic signed [FORCE_BITS-1:0] force_q [3];
  logic sat_d, sat_q, in_field_q, out_valid_q;
  logic [DIST_BITS-1:0] d_sel;

  // The whole back end moves as one when the output register can take a result.
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && q_valid_i;

  // Side data that rides along with each tick.
  always_comb begin
    side_d[0].item = item_i;
    side_d[0].d    = '0;
    for (int k = 1; k < N_STG; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[I_MUL].d = d_sel;
  end

  // Square root stages.
  always_comb begin
    sq_t init;
    init.num  = item_i.d2;
    init.rem  = '0;
    init.root = '0;
    sq_d[0] = sq_step(init);
    for (int s = 1; s < SQ_STAGES; s++) begin
      sq_d[s] = sq_step(sq_q[s-1]);
    end
  end

  // Distance and strength times remaining distance.
  always_comb begin
    logic [ROOT_BITS-1:0] root;
    root = sq_q[SQ_STAGES-1].root;
    if (!side_q[I_MUL-1].item.in_field || root == '0) begin
      d_sel = DIST_BITS'(1);
    end else begin
      d_sel = root[DIST_BITS-1:0];
    end
    if (side_q[I_MUL-1].item.in_field) begin
      prod_d = PROD_BITS'(cfg_i.strength) * PROD_BITS'(cfg_i.max_dist - d_sel);
    end else begin
      prod_d = '0;
    end
  end

  // Magnitude divider stages.
  always_comb begin
    dv1_t init;
    init.rem = prod_q[PROD_BITS-1:STR_BITS];
    init.lq  = prod_q[STR_BITS-1:0];
    dv_d[0] = dv1_step(init, cfg_i.max_dist);
    for (int s = 1; s < DV_STAGES; s++) begin
      dv_d[s] = dv1_step(dv_q[s-1], cfg_i.max_dist);
    end
  end

  // Clamp to the force limit; outside the field the magnitude is zero.
  always_comb begin
    logic [STR_BITS-1:0] q;
    q = dv_q[DV_STAGES-1].lq;
    if (!side_q[I_CLP-1].item.in_field) begin
      mag_d = '0;
    end else if (q > STR_BITS'(cfg_i.limit)) begin
      mag_d = cfg_i.limit;
    end else begin
      mag_d = q[LIM_BITS-1:0];
    end
  end

  // Rounded numerators magnitude times |v| plus half the distance.
  always_comb begin
    logic signed [VEC_BITS-1:0] vv;
    logic [VEC_BITS-1:0] av;
    for (int i = 0; i < 3; i++) begin
      vv = vec_of(side_q[I_NUM-1].item, i);
      av = vv[VEC_BITS-1] ? VEC_BITS'(-vv) : VEC_BITS'(vv);
      num_d[i] = NUM_BITS'(mag_q) * NUM_BITS'(av)
               + NUM_BITS'(side_q[I_NUM-1].d >> 1);
    end
  end

  // Direction divider stages, one lane per axis.
  always_comb begin
    dv2_t init;
    for (int i = 0; i < 3; i++) begin
      init.rem = DIST_BITS'(num_q[i][NUM_BITS-1:GQ_BITS]);
      init.lq  = num_q[i][GQ_BITS-1:0];
      dg_d[0][i] = dv2_step(init, side_q[I_DG0-1].d);
    end
    for (int s = 1; s < DG_STAGES; s++) begin
      for (int i = 0; i < 3; i++) begin
        dg_d[s][i] = dv2_step(dg_q[s-1][i], side_q[I_DG0+s-1].d);
      end
    end
  end

  // Signed global pull.
  always_comb begin
    logic signed [VEC_BITS-1:0] vv;
    logic signed [G_BITS-1:0] qe;
    for (int i = 0; i < 3; i++) begin
      vv = vec_of(side_q[I_GV-1].item, i);
      qe = {1'b0, dg_q[DG_STAGES-1][i].lq};
      g_d[i] = vv[VEC_BITS-1] ? -qe : qe;
    end
  end

  // Products of the transposed matrix with the pull.
  always_comb begin
    logic signed [PR_BITS-1:0] re;
    logic signed [PR_BITS-1:0] ge;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        re = PR_BITS'(rot_of(side_q[I_ROT-1].item, i, j));
        ge = PR_BITS'(g_q[i]);
        pr_d[j][i] = re * ge;
      end
    end
  end

  // Sum of the three products per local axis.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc_d[j] = ACC_BITS'(pr_q[j][0]) + ACC_BITS'(pr_q[j][1]) + ACC_BITS'(pr_q[j][2]);
    end
  end

  // Round half away from zero, add the contact force and saturate.
  always_comb begin
    logic [ACC_BITS-1:0] a;
    logic [ACC_BITS-1:0] p;
    logic signed [TOT_BITS-1:0] pe;
    logic signed [TOT_BITS-1:0] ce;
    logic signed [TOT_BITS-1:0] tot;
    sat_d = 1'b0;
    for (int j = 0; j < 3; j++) begin
      a   = acc_q[j][ACC_BITS-1] ? ACC_BITS'(-acc_q[j]) : ACC_BITS'(acc_q[j]);
      p   = (a + RND_HALF) >> ROT_FRAC_BITS;
      pe  = TOT_BITS'(p[RND_BITS-1:0]);
      ce  = TOT_BITS'(contact_of(side_q[I_ACC].item, j));
      tot = acc_q[j][ACC_BITS-1] ? ce - pe : ce + pe;
      if (tot > T_MAX) begin
        force_d[j] = F_MAX;
        sat_d      = 1'b1;
      end else if (tot < T_MIN) begin
        force_d[j] = F_MIN;
        sat_d      = 1'b1;
      end else begin
        force_d[j] = tot[FORCE_BITS-1:0];
      end
    end
  end

  // Stage valid bits and the output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N_STG; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= pop_o;
      for (int k = 1; k < N_STG; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_valid_q <= vld_q[N_STG-1];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < N_STG; k++) begin
        side_q[k] <= side_d[k];
      end
      for (int s = 0; s < SQ_STAGES; s++) begin
        sq_q[s] <= sq_d[s];
      end
      prod_q <= prod_d;
      for (int s = 0; s < DV_STAGES; s++) begin
        dv_q[s] <= dv_d[s];
      end
      mag_q <= mag_d;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= num_d[i];
        g_q[i]   <= g_d[i];
        acc_q[i] <= acc_d[i];
        force_q[i] <= force_d[i];
        for (int s = 0; s < DG_STAGES; s++) begin
          dg_q[s][i] <= dg_d[s][i];
        end
        for (int m = 0; m < 3; m++) begin
          pr_q[i][m] <= pr_d[i][m];
        end
      end
      sat_q      <= sat_d;
      in_field_q <= side_q[I_ACC].item.in_field;
    end
  end

  assign out_valid_o = out_valid_q;
  assign force_x_o   = force_q[0];
  assign force_y_o   = force_q[1];
  assign force_z_o   = force_q[2];
  assign in_field_o  = in_field_q;
  assign saturated_o = sat_q;

endmodule

### hdl/haptic_pull_force_unit.sv
// -----------------------------------------------------------------------------
// Haptic pull force unit
// Adds a pull toward a configured centre, rotated into tool coordinates, to
// the contact force of each haptic tick.
// -----------------------------------------------------------------------------
// The unit accepts one tick per clock cycle while in_stall_o is low and returns
// one result per tick, in order. A tick passes the two front-end registers and
// the queue, then the 69 back-end stages: 26 square root stages, the distance
// multiply, 20 magnitude divider stages, the clamp, the numerator, 16 direction
// divider stages, and the sign, rotate, sum and output registers. The front end
// feeds a four-entry queue; in_stall_o rises when the queue and the ticks still
// in the front end fill those four entries, so a stalled output backs up into
// the input. Configuration writes take effect for the field radii once the
// squared radii are registered from them, and should be made while the unit is
// idle.
`include "haptic_pull_force_unit_macros.svh"

module haptic_pull_force_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [hpf_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [hpf_pkg::CFG_BITS-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [hpf_pkg::POS_BITS-1:0]   tool_pos_x_i,
  input  logic signed [hpf_pkg::POS_BITS-1:0]   tool_pos_y_i,
  input  logic signed [hpf_pkg::POS_BITS-1:0]   tool_pos_z_i,
  input  logic [hpf_pkg::ROW_BITS-1:0]          rot_row0_i,
  input  logic [hpf_pkg::ROW_BITS-1:0]          rot_row1_i,
  input  logic [hpf_pkg::ROW_BITS-1:0]          rot_row2_i,
  input  logic signed [hpf_pkg::FORCE_BITS-1:0] contact_x_i,
  input  logic signed [hpf_pkg::FORCE_BITS-1:0] contact_y_i,
  input  logic signed [hpf_pkg::FORCE_BITS-1:0] contact_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [hpf_pkg::FORCE_BITS-1:0] force_x_o,
  output logic signed [hpf_pkg::FORCE_BITS-1:0] force_y_o,
  output logic signed [hpf_pkg::FORCE_BITS-1:0] force_z_o,
  output logic                                  in_field_o,
  output logic                                  saturated_o
);
  import hpf_pkg::*;

  cfg_t                 cfg_q;
  logic                 q_push, q_pop, q_valid;
  item_t                q_in, q_out;
  logic [QCNT_BITS-1:0] q_cnt;

  // Configuration registers; writes past the last index are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X: cfg_q.center_x <= cfg_data_i;
        CFG_CENTER_Y: cfg_q.center_y <= cfg_data_i;
        CFG_CENTER_Z: cfg_q.center_z <= cfg_data_i;
        CFG_MAX_DIST: cfg_q.max_dist <= cfg_data_i[DIST_BITS-1:0];
        CFG_MIN_DIST: cfg_q.min_dist <= cfg_data_i[DIST_BITS-1:0];
        CFG_STRENGTH: cfg_q.strength <= cfg_data_i[STR_BITS-1:0];
        CFG_LIMIT:    cfg_q.limit    <= cfg_data_i[LIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  hpf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .tool_pos_x_i (tool_pos_x_i),
    .tool_pos_y_i (tool_pos_y_i),
    .tool_pos_z_i (tool_pos_z_i),
    .rot_row0_i   (rot_row0_i),
    .rot_row1_i   (rot_row1_i),
    .rot_row2_i   (rot_row2_i),
    .contact_x_i  (contact_x_i),
    .contact_y_i  (contact_y_i),
    .contact_z_i  (contact_z_i),
    .q_cnt_i      (q_cnt),
    .push_o       (q_push),
    .item_o       (q_in)
  );

  hpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out),
    .cnt_o   (q_cnt)
  );

  hpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .item_i      (q_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .force_x_o   (force_x_o),
    .force_y_o   (force_y_o),
    .force_z_o   (force_z_o),
    .in_field_o  (in_field_o),
    .saturated_o (saturated_o)
  );

  // The credit scheme keeps the queue within its depth.
  `HPF_ASSERT(a_queue_bound, q_cnt <= QUEUE_DEPTH)
  // A push into a full queue only happens when an entry leaves in the same cycle.
  `HPF_ASSERT_IMP(a_push_room, q_push, q_cnt < QUEUE_DEPTH || q_pop)
  // The back end never takes a transaction from an empty queue.
  `HPF_ASSERT_IMP(a_pop_valid, q_pop, q_valid)
  // A saturated result has at least one component at a bound.
  `HPF_ASSERT_IMP(a_sat_bound, out_valid_o && saturated_o,
      force_x_o == F_MAX || force_x_o == F_MIN || force_y_o == F_MAX ||
      force_y_o == F_MIN || force_z_o == F_MAX || force_z_o == F_MIN)

endmodule

### bench/haptic_pull_force_unit_tb.sv
// -----------------------------------------------------------------------------
// Haptic pull force unit testbench
// Drives directed and random ticks through the unit with random gaps and
// output stalls, and checks every result against an in-bench force predictor.
// -----------------------------------------------------------------------------
module haptic_pull_force_unit_tb;
  import hpf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam int N_RANDOM = 400;
  localparam logic [47:0] ROT_IDENT = {16'sd0, 16'sd0, 16'sd16384};

  typedef struct {
    logic signed [FORCE_BITS-1:0] fx;
    logic signed [FORCE_BITS-1:0] fy;
    logic signed [FORCE_BITS-1:0] fz;
    logic                         in_field;
    logic                         saturated;
  } force_t;

  typedef struct {
    logic signed [POS_BITS-1:0]   px, py, pz;
    logic [ROW_BITS-1:0]          r0, r1, r2;
    logic signed [FORCE_BITS-1:0] cx, cy, cz;
  } tick_t;

  // A directed row; known marks a typed-in expected result.
  typedef struct {
    tick_t  tk;
    logic   known;
    force_t res;
  } vec_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_BITS-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [POS_BITS-1:0] tool_pos_x_i, tool_pos_y_i, tool_pos_z_i;
  logic [ROW_BITS-1:0] rot_row0_i, rot_row1_i, rot_row2_i;
  logic signed [FORCE_BITS-1:0] contact_x_i, contact_y_i, contact_z_i;
  logic signed [FORCE_BITS-1:0] force_x_o, force_y_o, force_z_o;
  logic in_field_o, saturated_o;

  haptic_pull_force_unit dut (.*);

  // Predictor copy of the register file.
  longint cen_x, cen_y, cen_z, max_d, min_d, strength, flimit;
  force_t expected_forces[$];
  int errors;
  longint cycles;
  bit stall_enable;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle counter and timeout.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("haptic_pull_force_unit_tb NOT OK");
        $finish;
      end
    end
  end

  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = ((num < 0 ? -num : num) + den / 2) / den;
    return num < 0 ? -mag : mag;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint res, bit_v;
    res = 0;
    bit_v = 64'sd1 <<< 62;
    while (bit_v > n) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  // Predicts the total local force of one tick.
  function automatic force_t predict_force(tick_t tk);
    longint v[3], g[3], d2, d, mag, acc, tot, flim;
    logic [ROW_BITS-1:0] rows[3];
    force_t r;
    flim = (64'sd1 <<< (FORCE_BITS - 1)) - 1;
    v[0] = cen_x - longint'(tk.px);
    v[1] = cen_y - longint'(tk.py);
    v[2] = cen_z - longint'(tk.pz);
    rows[0] = tk.r0; rows[1] = tk.r1; rows[2] = tk.r2;
    d2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    g[0] = 0; g[1] = 0; g[2] = 0;
    r.in_field = 1'b0;
    r.saturated = 1'b0;
    if (d2 > min_d * min_d && d2 < max_d * max_d) begin
      r.in_field = 1'b1;
      d = int_sqrt(d2);
      if (d == 0) d = 1;
      mag = strength * (max_d - d) / max_d;
      if (mag > flimit) mag = flimit;
      for (int i = 0; i < 3; i++) g[i] = round_div(mag * v[i], d);
    end
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int i = 0; i < 3; i++)
        acc += longint'($signed(rows[i][16*j +: 16])) * g[i];
      tot = round_div(acc, 64'sd1 <<< ROT_FRAC_BITS);
      tot += (j == 0) ? longint'(tk.cx) : (j == 1) ? longint'(tk.cy) : longint'(tk.cz);
      if (tot > flim) begin tot = flim; r.saturated = 1'b1; end
      if (tot < -flim) begin tot = -flim; r.saturated = 1'b1; end
      if (j == 0) r.fx = tot[FORCE_BITS-1:0];
      else if (j == 1) r.fy = tot[FORCE_BITS-1:0];
      else r.fz = tot[FORCE_BITS-1:0];
    end
    return r;
  endfunction

  // Output side: random stalls and the result check.
  always @(posedge clk_i) begin
    force_t exp_f;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_forces.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d", $time, force_x_o, force_y_o,
                 force_z_o);
        errors++;
      end else begin
        exp_f = expected_forces.pop_front();
        if (force_x_o !== exp_f.fx || force_y_o !== exp_f.fy ||
            force_z_o !== exp_f.fz || in_field_o !== exp_f.in_field ||
            saturated_o !== exp_f.saturated) begin
          $display("%0t: expected %0d %0d %0d f%b s%b, actual %0d %0d %0d f%b s%b",
                   $time, exp_f.fx, exp_f.fy, exp_f.fz, exp_f.in_field, exp_f.saturated,
                   force_x_o, force_y_o, force_z_o, in_field_o, saturated_o);
          errors++;
        end
      end
    end
    if (!stall_enable) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 99) < 3) out_stall_i <= 1'b1;
    else if ($urandom_range(0, 99) < 40) out_stall_i <= $urandom_range(0, 99) < 25;
  end

  // Writes one register, then leaves the port idle before returning.
  task automatic write_reg(cfg_idx_e idx, longint value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CFG_BITS-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    unique case (idx)
      CFG_CENTER_X: cen_x = longint'($signed(value[POS_BITS-1:0]));
      CFG_CENTER_Y: cen_y = longint'($signed(value[POS_BITS-1:0]));
      CFG_CENTER_Z: cen_z = longint'($signed(value[POS_BITS-1:0]));
      CFG_MAX_DIST: max_d = value & 64'h7FFFFF;
      CFG_MIN_DIST: min_d = value & 64'h7FFFFF;
      CFG_STRENGTH: strength = value & 64'hFFFFF;
      CFG_LIMIT:    flimit = value & 64'h7FFF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Waits until every expected result has come, then lets the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Presents one tick and holds it until accepted; maybe idles first.
  task automatic send_tick(tick_t tk, bit gaps);
    int gap;
    if (gaps) begin
      gap = ($urandom_range(0, 99) < 5) ? $urandom_range(10, 60) :
            ($urandom_range(0, 99) < 40 ? $urandom_range(1, 3) : 0);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    tool_pos_x_i <= tk.px; tool_pos_y_i <= tk.py; tool_pos_z_i <= tk.pz;
    rot_row0_i <= tk.r0; rot_row1_i <= tk.r1; rot_row2_i <= tk.r2;
    contact_x_i <= tk.cx; contact_y_i <= tk.cy; contact_z_i <= tk.cz;
    do @(posedge clk_i); while (in_stall_o);
    expected_forces.push_back(predict_force(tk));
  endtask

  function automatic logic [ROW_BITS-1:0] rand_row(bit unit_like);
    logic [ROW_BITS-1:0] r;
    r = ROW_BITS'({$urandom, $urandom});
    if (unit_like)
      for (int k = 0; k < 3; k++) r[16*k +: 16] = 16'($urandom_range(0, 32767) - 16384);
    return r;
  endfunction

  // Random tick near the centre, or anywhere in the position range.
  function automatic tick_t rand_tick();
    tick_t tk;
    longint span;
    span = ($urandom_range(0, 3) == 0) ? 8388607 : max_d + 2000;
    if ($urandom_range(0, 4) == 0) begin
      tk.px = POS_BITS'($urandom); tk.py = POS_BITS'($urandom); tk.pz = POS_BITS'($urandom);
    end else begin
      tk.px = POS_BITS'(cen_x + $urandom_range(0, 2 * span) - span);
      tk.py = POS_BITS'(cen_y + $urandom_range(0, 2 * span) - span);
      tk.pz = POS_BITS'(cen_z + $urandom_range(0, 2 * span) - span);
    end
    tk.r0 = rand_row($urandom_range(0, 1)); tk.r1 = rand_row($urandom_range(0, 1));
    tk.r2 = rand_row($urandom_range(0, 1));
    tk.cx = FORCE_BITS'(($urandom_range(0, 3) == 0) ? $urandom :
                        $urandom_range(0, 4000) - 2000);
    tk.cy = FORCE_BITS'(($urandom_range(0, 3) == 0) ? $urandom :
                        $urandom_range(0, 4000) - 2000);
    tk.cz = FORCE_BITS'(($urandom_range(0, 3) == 0) ? $urandom :
                        $urandom_range(0, 4000) - 2000);
    return tk;
  endfunction

  function automatic tick_t mk(longint px, longint py, longint pz, logic [47:0] r0,
                               logic [47:0] r1, logic [47:0] r2,
                               longint cx, longint cy, longint cz);
    tick_t tk;
    tk.px = POS_BITS'(px); tk.py = POS_BITS'(py); tk.pz = POS_BITS'(pz);
    tk.r0 = r0; tk.r1 = r1; tk.r2 = r2;
    tk.cx = FORCE_BITS'(cx); tk.cy = FORCE_BITS'(cy); tk.cz = FORCE_BITS'(cz);
    return tk;
  endfunction

  function automatic force_t fr(longint x, longint y, longint z, bit f, bit s);
    force_t r;
    r.fx = FORCE_BITS'(x); r.fy = FORCE_BITS'(y); r.fz = FORCE_BITS'(z);
    r.in_field = f; r.saturated = s;
    return r;
  endfunction

  // Main sequence.
  initial begin
    vec_t dir_vecs[$];
    vec_t row;
    force_t got;
    logic [47:0] ry, rz;
    errors = 0;
    stall_enable = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0;
    tool_pos_x_i = '0; tool_pos_y_i = '0; tool_pos_z_i = '0;
    rot_row0_i = '0; rot_row1_i = '0; rot_row2_i = '0;
    contact_x_i = '0; contact_y_i = '0; contact_z_i = '0;
    cen_x = 0; cen_y = 0; cen_z = 0;
    max_d = MAX_RST; min_d = MIN_RST; strength = STR_RST; flimit = LIM_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    ry = {16'sd0, 16'sd16384, 16'sd0};
    rz = {16'sd16384, 16'sd0, 16'sd0};

    // Directed table on reset settings; typed results only where obvious.
    row.known = 1;
    // At the centre: inside the dead radius, contact passes through.
    row.tk = mk(0, 0, 0, ROT_IDENT, ry, rz, 123, -456, 789);
    row.res = fr(123, -456, 789, 0, 0); dir_vecs.push_back(row);
    // Far away: no pull; contact extremes saturate.
    row.tk = mk(8388607, 8388607, 8388607, ROT_IDENT, ry, rz, 32767, -32768, 0);
    row.res = fr(32767, -32767, 0, 0, 1); dir_vecs.push_back(row);
    row.tk = mk(-8388608, -8388608, -8388608, '1, '1, '1, -32768, 32767, -1);
    row.res = fr(-32767, 32767, -1, 0, 1); dir_vecs.push_back(row);
    // Exactly on the inner and outer radii: outside the field.
    row.tk = mk(-1000, 0, 0, ROT_IDENT, ry, rz, 0, 0, 0);
    row.res = fr(0, 0, 0, 0, 0); dir_vecs.push_back(row);
    row.tk = mk(0, -80000, 0, ROT_IDENT, ry, rz, 5, 5, 5);
    row.res = fr(5, 5, 5, 0, 0); dir_vecs.push_back(row);
    // Just past the inner radius edge, inside the field: clamped to the limit along +x.
    row.tk = mk(-1001, 0, 0, ROT_IDENT, ry, rz, 0, 0, 0);
    row.res = fr(3000, 0, 0, 1, 0); dir_vecs.push_back(row);
    row.known = 0;
    row.tk = mk(0, 0, 79999, ROT_IDENT, ry, rz, 0, 0, 0); dir_vecs.push_back(row);
    row.tk = mk(30000, -20000, 10000, ry, rz, ROT_IDENT, 32000, -32000, 0);
    dir_vecs.push_back(row);
    row.tk = mk(-5000, 5000, 5000, '1, {16'h8000, 16'h7FFF, 16'h8000}, '0, 0, 0, 0);
    dir_vecs.push_back(row);
    row.tk = mk(40000, 40000, 0, {48{1'b1}} >> 1, 48'h8000_8000_8000, rz, 100, 100, 100);
    dir_vecs.push_back(row);

    foreach (dir_vecs[k]) begin
      if (dir_vecs[k].known) begin
        got = predict_force(dir_vecs[k].tk);
        if (got.fx !== dir_vecs[k].res.fx || got.fy !== dir_vecs[k].res.fy ||
            got.fz !== dir_vecs[k].res.fz || got.in_field !== dir_vecs[k].res.in_field ||
            got.saturated !== dir_vecs[k].res.saturated) begin
          $display("%0t: table row %0d expected %0d %0d %0d, predictor %0d %0d %0d",
                   $time, k, dir_vecs[k].res.fx, dir_vecs[k].res.fy, dir_vecs[k].res.fz,
                   got.fx, got.fy, got.fz);
          errors++;
        end
      end
      send_tick(dir_vecs[k].tk, 0);
    end
    drain();

    // Extreme register settings: zero strength, zero limit, wide field.
    write_reg(CFG_STRENGTH, 0);
    send_tick(mk(-2000, 0, 0, ROT_IDENT, ry, rz, 7, 7, 7), 0);
    drain();
    write_reg(CFG_STRENGTH, 1048575);
    write_reg(CFG_LIMIT, 0);
    send_tick(mk(0, 3000, 0, ROT_IDENT, ry, rz, 7, 7, 7), 0);
    drain();
    write_reg(CFG_LIMIT, 32767);
    write_reg(CFG_MAX_DIST, 8388607);
    write_reg(CFG_MIN_DIST, 0);
    write_reg(CFG_CENTER_X, -8388608);
    write_reg(CFG_CENTER_Y, 8388607);
    write_reg(CFG_CENTER_Z, 0);
    for (int k = 0; k < 6; k++) send_tick(rand_tick(), 0);
    send_tick(mk(-8388608, 8388607, 0, ROT_IDENT, ry, rz, 0, 0, 0), 0);
    send_tick(mk(8388607, -8388608, 0, ROT_IDENT, ry, rz, 0, 0, 0), 0);
    drain();

    // Random phases with random settings and both sides idling.
    stall_enable = 1;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_CENTER_X, $urandom);
      write_reg(CFG_CENTER_Y, $urandom);
      write_reg(CFG_CENTER_Z, $urandom);
      write_reg(CFG_MAX_DIST, (ph == 0) ? 1 : $urandom_range(1000, 3000000));
      write_reg(CFG_MIN_DIST, (ph == 1) ? 8388607 : $urandom_range(0, 1500));
      write_reg(CFG_STRENGTH, $urandom);
      write_reg(CFG_LIMIT, (ph == 2) ? 32767 : $urandom);
      // An index past the register file is ignored.
      cfg_we_i <= 1'b1; cfg_idx_i <= '1; cfg_data_i <= CFG_BITS'($urandom);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      for (int k = 0; k < N_RANDOM / 8; k++) begin
        send_tick(rand_tick(), ph != 3);
        if (k == 25) begin
          in_valid_i <= 1'b0;
          while (expected_forces.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (errors == 0) $display("haptic_pull_force_unit_tb OK");
    else $display("haptic_pull_force_unit_tb NOT OK");
    $finish;
  end
endmodule
